// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent holds on the edge after the antecedent
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/slbc_pkg.sv
// ----------------------------------------------------------------------------
// slbc_pkg
// Types and constants for the status LED blink controller.
// ----------------------------------------------------------------------------
package slbc_pkg;

   localparam int unsigned TIME_BITS_DEF  = 16;
   localparam int unsigned COUNT_BITS_DEF = 8;

   // on and off time after reset, in ms
   localparam int unsigned DEFAULT_TIME = 500;

   typedef enum logic [1:0] {
      MODE_SOLID  = 2'd0,
      MODE_BLINK  = 2'd1,
      MODE_SINGLE = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REQ_TICK       = 3'd0,
      REQ_SET_SOLID  = 3'd1,
      REQ_BLINK      = 3'd2,
      REQ_BLINK_ONCE = 3'd3,
      REQ_SET_MODE   = 3'd4
   } req_kind_type;

endpackage

// File: rtl/core/status_led_blink_controller_unit.sv
// ----------------------------------------------------------------------------
// status_led_blink_controller_unit
// Status LED driver: solid, grouped blinking and single toggle modes.
// ----------------------------------------------------------------------------
// Each request (ms tick or command) is captured in an input register, then
// one pass of compare/decrement logic updates the LED state and the one-shot
// timer and writes the result register, so a request passes the input and
// result registers in turn. A new request can be taken every cycle while the
// result side does not stall; the throughput of one request per cycle is set
// by the single state-update pass between the input and result registers.
// A stalled result holds the input register, which then stalls the request
// side.

`include "assert_macros.svh"

module status_led_blink_controller_unit #(
   parameter int unsigned TIME_BITS  = slbc_pkg::TIME_BITS_DEF,
   parameter int unsigned COUNT_BITS = slbc_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic        req_level,
   input  logic [1:0]  req_mode_sel,
   input  logic [15:0] req_on_time,
   input  logic [15:0] req_off_time,
   input  logic [7:0]  req_repeat_count,
   input  logic [15:0] req_gap_time,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_led_on,
   output logic [1:0]  rsp_mode_now
);

   localparam logic [TIME_BITS-1:0] DEF_TIME = TIME_BITS'(slbc_pkg::DEFAULT_TIME);
   localparam logic [TIME_BITS-1:0] ONE_MS   = TIME_BITS'(1);

   typedef struct packed {
      slbc_pkg::mode_type    mode;
      logic                  solid;
      logic [TIME_BITS-1:0]  on_t;
      logic [TIME_BITS-1:0]  off_t;
      logic [COUNT_BITS-1:0] rep;
      logic [TIME_BITS-1:0]  gap;
      logic [COUNT_BITS-1:0] cnt;
   } setting_type;

   localparam setting_type SETTING_RST = '{
      mode:  slbc_pkg::MODE_SOLID,
      solid: 1'b0,
      on_t:  DEF_TIME,
      off_t: DEF_TIME,
      rep:   '0,
      gap:   '0,
      cnt:   '0
   };

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [2:0]            in_type_ff;
   logic                  in_level_ff;
   logic [1:0]            in_mode_ff;
   logic [15:0]           in_on_ff;
   logic [15:0]           in_off_ff;
   logic [7:0]            in_rep_ff;
   logic [15:0]           in_gap_ff;

   // controller state
   setting_type           cur_ff, cur_in;
   setting_type           saved_ff, saved_in;
   logic                  led_ff, led_in;
   logic [TIME_BITS-1:0]  rem_ff, rem_in;
   logic                  run_ff, run_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_led_ff;
   slbc_pkg::mode_type    rsp_mode_ff;

   logic                  advance;
   logic [TIME_BITS-1:0]  on_w, off_raw_w, gap_w;
   logic [COUNT_BITS-1:0] rep_w;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   assign on_w      = TIME_BITS'(in_on_ff);
   assign off_raw_w = TIME_BITS'(in_off_ff);
   assign gap_w     = TIME_BITS'(in_gap_ff);
   assign rep_w     = COUNT_BITS'(in_rep_ff);

   always_comb begin
      logic                 do_enter;
      slbc_pkg::mode_type   enter_mode;
      logic [TIME_BITS-1:0] off_w;

      cur_in     = cur_ff;
      saved_in   = saved_ff;
      led_in     = led_ff;
      rem_in     = rem_ff;
      run_in     = run_ff;
      do_enter   = 1'b0;
      enter_mode = slbc_pkg::MODE_SOLID;
      off_w      = (off_raw_w == '0) ? on_w : off_raw_w;

      if (advance) begin
         unique case (in_type_ff)
            slbc_pkg::REQ_TICK: begin
               if (run_ff) begin
                  if (rem_ff > ONE_MS) begin
                     rem_in = rem_ff - ONE_MS;
                  end else begin
                     rem_in = '0;
                     run_in = 1'b0;
                     case (cur_ff.mode)
                        slbc_pkg::MODE_BLINK: begin
                           run_in = 1'b1;
                           if (led_ff) begin
                              led_in = 1'b0;
                              rem_in = cur_ff.off_t;
                              if (cur_ff.rep != '0) begin
                                 if (cur_ff.cnt < cur_ff.rep) begin
                                    cur_in.cnt = cur_ff.cnt + COUNT_BITS'(1);
                                 end else begin
                                    // group done: clear count, pause for the gap
                                    cur_in.cnt = '0;
                                    rem_in     = cur_ff.gap;
                                 end
                              end
                           end else begin
                              led_in = 1'b1;
                              rem_in = cur_ff.on_t;
                           end
                        end
                        slbc_pkg::MODE_SINGLE: begin
                           // toggle back, then restore and re-enter the saved mode
                           led_in     = ~led_ff;
                           cur_in     = saved_ff;
                           do_enter   = 1'b1;
                           enter_mode = saved_ff.mode;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            slbc_pkg::REQ_SET_SOLID: begin
               cur_in.solid = in_level_ff;
               do_enter     = 1'b1;
               enter_mode   = slbc_pkg::MODE_SOLID;
            end
            slbc_pkg::REQ_BLINK: begin
               cur_in.on_t  = on_w;
               cur_in.off_t = off_w;
               cur_in.rep   = rep_w;
               cur_in.gap   = gap_w;
               do_enter     = 1'b1;
               enter_mode   = slbc_pkg::MODE_BLINK;
            end
            slbc_pkg::REQ_BLINK_ONCE: begin
               if (cur_ff.mode != slbc_pkg::MODE_SINGLE) begin
                  saved_in     = cur_ff;
                  cur_in.on_t  = on_w;
                  cur_in.off_t = on_w;
                  cur_in.rep   = rep_w;
                  do_enter     = 1'b1;
                  enter_mode   = slbc_pkg::MODE_SINGLE;
               end
            end
            slbc_pkg::REQ_SET_MODE: begin
               if (in_mode_ff <= slbc_pkg::MODE_SINGLE) begin
                  do_enter   = 1'b1;
                  enter_mode = slbc_pkg::mode_type'(in_mode_ff);
               end
            end
            default: begin
            end
         endcase
      end

      if (do_enter) begin
         cur_in.mode = enter_mode;
         case (enter_mode)
            slbc_pkg::MODE_SOLID: begin
               led_in = cur_in.solid;
            end
            slbc_pkg::MODE_BLINK: begin
               led_in = 1'b1;
               rem_in = cur_in.on_t;
               run_in = 1'b1;
            end
            default: begin
               led_in = ~led_in;
               rem_in = cur_in.on_t;
               run_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= SETTING_RST;
         saved_ff     <= SETTING_RST;
         led_ff       <= 1'b0;
         rem_ff       <= '0;
         run_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         saved_ff     <= saved_in;
         led_ff       <= led_in;
         rem_ff       <= rem_in;
         run_ff       <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_type_ff  <= req_type;
         in_level_ff <= req_level;
         in_mode_ff  <= req_mode_sel;
         in_on_ff    <= req_on_time;
         in_off_ff   <= req_off_time;
         in_rep_ff   <= req_repeat_count;
         in_gap_ff   <= req_gap_time;
      end
      if (advance) begin
         rsp_led_ff  <= led_in;
         rsp_mode_ff <= cur_in.mode;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_led_on   = rsp_led_ff;
   assign rsp_mode_now = rsp_mode_ff;

   // a stopped timer always reads zero
   `ASSERT_ALWAYS(a_timer_idle_zero, clock, reset, run_ff || (rem_ff == '0))
   // in solid mode the LED follows the solid level
   `ASSERT_ALWAYS(a_solid_level, clock, reset,
      (cur_ff.mode != slbc_pkg::MODE_SOLID) || (led_ff == cur_ff.solid))
   // a processed request always lands in the result register
   `ASSERT_NEXT(a_advance_result, clock, reset, advance, rsp_valid_ff)

endmodule
